// ===== src/lpr_pkg.sv =====
// lpr_pkg: shared constants, types and control structs of the LED panel pixel remapper
// used by lpr_ctrl, lpr_datapath and led_panel_pixel_remap_top; depends on nothing

package lpr_pkg;

  // frame store geometry
  localparam int unsigned STORE_DEPTH   = 2048;
  localparam int unsigned COLUMN_GROUPS = 4;
  localparam int unsigned MAX_PANELS    = 5;
  localparam int unsigned ADDR_W        = $clog2(STORE_DEPTH);
  localparam int unsigned GRP_W         = $clog2(COLUMN_GROUPS);
  // width of the byte offset arithmetic (group size times groups, head and data offsets)
  localparam int unsigned CALC_W        = 13;

  // address calculation chain length, transfer to dispatch
  localparam int unsigned CALC_STEPS    = 7;
  localparam int unsigned CALC_CNT_W    = $clog2(CALC_STEPS);

  // stream widths
  localparam int unsigned S_TDATA_W     = 32;
  localparam int unsigned M_TDATA_W     = 8;

  // configuration port
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 9;

  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_PANEL_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_PANEL_COLUMNS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_PANEL_COLUMNS = 3'd4;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CALC_W-1:0] calc_t;

  // item kinds carried in the input tuser
  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  // input tdata layout, lowest bits last
  typedef struct packed {
    logic [6:0]  pad;
    logic [10:0] byte_index;
    logic        pixel_lit;
    logic [4:0]  pixel_y;
    logic [7:0]  pixel_x;
  } s_data_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic clr_step;
    logic mem_rd_pixel;
    logic mem_rd_byte;
    logic wr_pixel;
    logic wr_head;
    logic out_reject;
    logic out_read;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic reject;
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== src/lpr_ram.sv =====
// lpr_ram: generic single write port, single read port RAM with registered read
// no dependencies

module lpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lpr_ctrl.sv =====
// lpr_ctrl: sequencer of the LED panel pixel remapper (clear sweep, address chain, store access)
// depends on lpr_pkg

module lpr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  logic [1:0]           s_kind_i,
  input  logic                 s_lit_i,
  output logic                 s_ready_o,
  input  lpr_pkg::dp_stat_t    stat_i,
  output lpr_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_PX_RD,
    ST_PX_WR,
    ST_PX_HEAD,
    ST_RD_ISSUE,
    ST_RD_DATA,
    ST_REJECT
  } state_e;

  state_e                          state_q, state_d;
  logic [lpr_pkg::CALC_CNT_W-1:0]  calc_cnt_q, calc_cnt_d;
  logic                            is_read_q, is_read_d;
  lpr_pkg::kind_e                  kind;

  assign kind = lpr_pkg::kind_e'(s_kind_i);

  // next state and commands
  always_comb begin
    state_d    = state_q;
    calc_cnt_d = calc_cnt_q;
    is_read_d  = is_read_q;
    cmd_o      = '0;
    s_ready_o  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_ready_o       = 1'b1;
        cmd_o.load_item = s_valid_i;
        calc_cnt_d      = '0;
        if (s_valid_i) begin
          is_read_d = (kind == lpr_pkg::KIND_READ);
          case (kind)
            lpr_pkg::KIND_CLEAR: state_d = ST_CLEAR;
            lpr_pkg::KIND_PIXEL: state_d = s_lit_i ? ST_CALC : ST_IDLE;
            lpr_pkg::KIND_READ:  state_d = ST_CALC;
            default:             state_d = ST_IDLE;
          endcase
        end
      end
      ST_CALC: begin
        if (calc_cnt_q == lpr_pkg::CALC_CNT_W'(lpr_pkg::CALC_STEPS - 1)) begin
          if (is_read_q) begin
            state_d = ST_RD_ISSUE;
          end else if (stat_i.reject) begin
            state_d = ST_REJECT;
          end else begin
            state_d = ST_PX_RD;
          end
        end else begin
          calc_cnt_d = calc_cnt_q + 1'b1;
        end
      end
      ST_PX_RD: begin
        cmd_o.mem_rd_pixel = 1'b1;
        state_d            = ST_PX_WR;
      end
      ST_PX_WR: begin
        cmd_o.wr_pixel = 1'b1;
        state_d        = ST_PX_HEAD;
      end
      ST_PX_HEAD: begin
        cmd_o.wr_head = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_RD_ISSUE: begin
        cmd_o.mem_rd_byte = 1'b1;
        state_d           = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        if (stat_i.out_free) begin
          cmd_o.out_read = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_REJECT: begin
        if (stat_i.out_free) begin
          cmd_o.out_reject = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      calc_cnt_q <= '0;
      is_read_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      calc_cnt_q <= calc_cnt_d;
      is_read_q  <= is_read_d;
    end
  end

endmodule

// ===== src/lpr_datapath.sv =====
// lpr_datapath: configuration registers, address calculation chain, frame store and output register
// depends on lpr_pkg and lpr_ram

module lpr_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lpr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lpr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  lpr_pkg::s_data_t                  s_data_i,
  input  lpr_pkg::ctrl_cmd_t                cmd_i,
  output lpr_pkg::dp_stat_t                 stat_o,
  output logic                              m_valid_o,
  output logic [lpr_pkg::M_TDATA_W-1:0]     m_data_o,
  output logic                              m_user_o,
  input  logic                              m_ready_i
);

  localparam int unsigned GW = lpr_pkg::GRP_W;

  // configuration registers
  logic [8:0] dw_q;
  logic [5:0] dh_q;
  logic [2:0] fpc_q;
  logic [6:0] fcol_q;
  logic [6:0] tcol_q;

  // held item
  logic [7:0]  x_q;
  logic [4:0]  y_q;
  logic [10:0] idx_q;

  // stage 1
  logic [3:0] regs_q, regs_d;
  logic [2:0] ncap_q, ncap_d;
  logic       xbad_q, xbad_d;
  logic [2:0] rowreg_q, rowreg_d;
  logic [2:0] bit_q, bit_d;
  logic [9:0] span_q, span_d;
  logic [7:0] fcol2_q, fcol2_d;
  logic [8:0] fcol3_q, fcol3_d;
  logic [5:0] yrev;
  // stage 2
  logic [7:0] tsec_q, tsec_d;
  logic [7:0] fsec_q, fsec_d;
  logic       tail_q, tail_d;
  logic [1:0] p_q, p_d;
  logic [8:0] pfpc_q, pfpc_d;
  logic       rej2_q, rej2_d;
  logic       ge1, ge2, ge3;
  // stage 3
  logic [10:0] gsz_q, gsz_d;
  logic [7:0]  xin_q, xin_d;
  logic [6-GW:0] cpg_q, cpg_d;
  logic [1:0]  pidx_q, pidx_d;
  // stage 4
  logic [7-GW:0]       col;
  logic                rej4_q, rej4_d;
  logic [6-GW:0]       cp_q, cp_d;
  lpr_pkg::calc_t      base_q, base_d;
  logic [10:0]         off_q, off_d;
  lpr_pkg::calc_t      total_q, total_d;
  // stage 5
  lpr_pkg::calc_t      head_q, head_d;
  logic [8:0]          cpofs_q, cpofs_d;
  // stage 6
  lpr_pkg::calc_t      data_q, data_d;
  logic                rej_q, rej_d;
  logic                oor_q, oor_d;

  // clearing sweep and store ports
  lpr_pkg::addr_t clr_addr_q;
  logic           clr_last;
  logic           mem_we, mem_re;
  lpr_pkg::addr_t mem_waddr, mem_raddr;
  logic [7:0]     mem_wdata, mem_rdata;

  // output register
  logic       m_valid_q;
  logic [7:0] m_data_q, m_data_d;
  logic       m_user_q, m_user_d;
  logic       out_load;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dw_q   <= 9'd128;
      dh_q   <= 6'd19;
      fpc_q  <= 3'd4;
      fcol_q <= 7'd32;
      tcol_q <= 7'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lpr_pkg::REG_DISPLAY_WIDTH:      dw_q   <= cfg_data_i[8:0];
        lpr_pkg::REG_DISPLAY_HEIGHT:     dh_q   <= cfg_data_i[5:0];
        lpr_pkg::REG_FULL_PANEL_COUNT:   fpc_q  <= cfg_data_i[2:0];
        lpr_pkg::REG_FULL_PANEL_COLUMNS: fcol_q <= cfg_data_i[6:0];
        lpr_pkg::REG_TAIL_PANEL_COLUMNS: tcol_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // item capture on input transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      x_q   <= s_data_i.pixel_x;
      y_q   <= s_data_i.pixel_y;
      idx_q <= s_data_i.byte_index;
    end
  end

  // stage 1: rows, panel count clamp, bounds check, row reversal, full span
  always_comb begin
    regs_d   = 4'((7'(dh_q) + 7'd7) >> 3);
    ncap_d   = (fpc_q > 3'(lpr_pkg::MAX_PANELS - 1)) ? 3'(lpr_pkg::MAX_PANELS - 1) : fpc_q;
    xbad_d   = (9'(x_q) >= dw_q) || (6'(y_q) >= dh_q);
    yrev     = dh_q - 6'd1 - 6'(y_q);
    rowreg_d = yrev[5:3];
    bit_d    = ~yrev[2:0];
    span_d   = 10'(ncap_d) * 10'(fcol_q);
    fcol2_d  = {fcol_q, 1'b0};
    fcol3_d  = 9'(fcol_q) + 9'({fcol_q, 1'b0});
  end

  // stage 2: section sizes, tail or full panel, panel index by compare
  always_comb begin
    tsec_d = (tcol_q == 7'd0) ? 8'd0
           : 8'(9'(tcol_q[6:GW]) * 9'(regs_q) + 9'd1);
    fsec_d = 8'(9'(fcol_q[6:GW]) * 9'(regs_q) + 9'd1);
    tail_d = (tcol_q != 7'd0) && (10'(x_q) >= span_q);
    ge3    = (9'(x_q) >= fcol3_q) && (ncap_q > 3'd3);
    ge2    = (9'(x_q) >= 9'(fcol2_q)) && (ncap_q > 3'd2);
    ge1    = (x_q >= 8'(fcol_q)) && (ncap_q > 3'd1);
    if (ge3) begin
      p_d    = 2'd3;
      pfpc_d = fcol3_q;
    end else if (ge2) begin
      p_d    = 2'd2;
      pfpc_d = 9'(fcol2_q);
    end else if (ge1) begin
      p_d    = 2'd1;
      pfpc_d = 9'(fcol_q);
    end else begin
      p_d    = 2'd0;
      pfpc_d = 9'd0;
    end
    rej2_d = xbad_q || (!tail_d && ((fcol_q == 7'd0) || (10'(x_q) >= span_q)));
  end

  // stage 3: group size, column within panel, reversed panel slot
  always_comb begin
    gsz_d  = 11'(tsec_q) + 11'(11'(ncap_q) * 11'(fsec_q));
    xin_d  = tail_q ? 8'(10'(x_q) - span_q) : 8'(9'(x_q) - pfpc_q);
    cpg_d  = tail_q ? tcol_q[6:GW] : fcol_q[6:GW];
    pidx_d = 2'(ncap_q - 3'd1 - 3'(p_q));
  end

  // stage 4: mirrored column pair, group base, section offset
  always_comb begin
    col     = xin_q[7:GW];
    rej4_d  = rej2_q || (col >= (8-GW)'(cpg_q));
    cp_d    = (7-GW)'(cpg_q - (7-GW)'(1) - (7-GW)'(col));
    base_d  = lpr_pkg::calc_t'(x_q[GW-1:0]) * lpr_pkg::calc_t'(gsz_q);
    off_d   = tail_q ? 11'd0 : 11'(tsec_q) + 11'(11'(pidx_q) * 11'(fsec_q));
    total_d = lpr_pkg::calc_t'(gsz_q) << GW;
  end

  // stage 5: header address and data offset within the section
  always_comb begin
    head_d  = base_q + lpr_pkg::calc_t'(off_q);
    cpofs_d = 9'(9'(cp_q) * 9'(regs_q)) + 9'(rowreg_q) + 9'd1;
  end

  // stage 6: data address, bounds against the store
  always_comb begin
    data_d = head_q + lpr_pkg::calc_t'(cpofs_q);
    rej_d  = rej4_q
          || (head_q >= lpr_pkg::calc_t'(lpr_pkg::STORE_DEPTH))
          || (data_d >= lpr_pkg::calc_t'(lpr_pkg::STORE_DEPTH));
    oor_d  = (lpr_pkg::calc_t'(idx_q) >= total_q)
          || (lpr_pkg::calc_t'(idx_q) >= lpr_pkg::calc_t'(lpr_pkg::STORE_DEPTH));
  end

  // calculation chain registers, settle while the item is held
  always_ff @(posedge clk_i) begin
    regs_q   <= regs_d;
    ncap_q   <= ncap_d;
    xbad_q   <= xbad_d;
    rowreg_q <= rowreg_d;
    bit_q    <= bit_d;
    span_q   <= span_d;
    fcol2_q  <= fcol2_d;
    fcol3_q  <= fcol3_d;
    tsec_q   <= tsec_d;
    fsec_q   <= fsec_d;
    tail_q   <= tail_d;
    p_q      <= p_d;
    pfpc_q   <= pfpc_d;
    rej2_q   <= rej2_d;
    gsz_q    <= gsz_d;
    xin_q    <= xin_d;
    cpg_q    <= cpg_d;
    pidx_q   <= pidx_d;
    rej4_q   <= rej4_d;
    cp_q     <= cp_d;
    base_q   <= base_d;
    off_q    <= off_d;
    total_q  <= total_d;
    head_q   <= head_d;
    cpofs_q  <= cpofs_d;
    data_q   <= data_d;
    rej_q    <= rej_d;
    oor_q    <= oor_d;
  end

  // clearing sweep address
  assign clr_last = (clr_addr_q == lpr_pkg::addr_t'(lpr_pkg::STORE_DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_addr_q <= clr_last ? '0 : clr_addr_q + 1'b1;
    end
  end

  // store port selection
  always_comb begin
    mem_we    = cmd_i.clr_step | cmd_i.wr_pixel | cmd_i.wr_head;
    mem_waddr = lpr_pkg::addr_t'(head_q);
    mem_wdata = 8'(x_q[GW-1:0]);
    if (cmd_i.clr_step) begin
      mem_waddr = clr_addr_q;
      mem_wdata = 8'd0;
    end else if (cmd_i.wr_pixel) begin
      mem_waddr = lpr_pkg::addr_t'(data_q);
      mem_wdata = mem_rdata | (8'd1 << bit_q);
    end
    mem_re    = cmd_i.mem_rd_pixel | cmd_i.mem_rd_byte;
    mem_raddr = cmd_i.mem_rd_pixel ? lpr_pkg::addr_t'(data_q) : lpr_pkg::addr_t'(idx_q);
  end

  lpr_ram #(
    .WIDTH (8),
    .DEPTH (lpr_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register
  assign out_load = cmd_i.out_reject | cmd_i.out_read;

  always_comb begin
    if (cmd_i.out_reject) begin
      m_data_d = 8'd0;
      m_user_d = 1'b1;
    end else begin
      m_data_d = oor_q ? 8'd0 : mem_rdata;
      m_user_d = oor_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= m_data_d;
      m_user_q <= m_user_d;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_user_o  = m_user_q;

  // status to the sequencer
  assign stat_o.reject   = rej_q;
  assign stat_o.clr_last = clr_last;
  assign stat_o.out_free = !m_valid_q || m_ready_i;

endmodule

// ===== src/led_panel_pixel_remap_top.sv =====
// led_panel_pixel_remap_top: frame image builder for a chain of column-multiplexed LED panels
// depends on lpr_pkg, lpr_ctrl, lpr_datapath (which holds lpr_ram)
//
//   channel   direction  tdata (low bit first)                       tuser
//   s_axis    in         pixel_x, pixel_y, pixel_lit, byte_index     kind
//   m_axis    out        read_data                                   out_of_range
//   cfg       in         write enable, register index, write data    -
//
// after reset a clearing pass over all 2048 store bytes runs with s_axis_tready low
// a clear item reruns that pass; an unlit pixel or an unused kind is dropped when taken
// a placed pixel is taken, passes the address chain (six register stages and the
//   decision), then store read, data write and header write
// a rejected pixel passes the chain, a read item the chain and a store read; both wait for a free output register
// the output register holds a result until m_axis_tready; a new item is taken meanwhile

module led_panel_pixel_remap_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [lpr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lpr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input items
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [lpr_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // pixel_x, pixel_y, pixel_lit, byte_index
  input  logic [1:0]                         s_axis_tuser,  // kind
  // results
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [lpr_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // read_data
  output logic                               m_axis_tuser   // out_of_range
);

  lpr_pkg::s_data_t   s_data;
  lpr_pkg::ctrl_cmd_t cmd;
  lpr_pkg::dp_stat_t  stat;

  assign s_data = lpr_pkg::s_data_t'(s_axis_tdata);

  lpr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_kind_i  (s_axis_tuser),
    .s_lit_i   (s_data.pixel_lit),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  lpr_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_data_i   (s_data),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .m_valid_o  (m_axis_tvalid),
    .m_data_o   (m_axis_tdata),
    .m_user_o   (m_axis_tuser),
    .m_ready_i  (m_axis_tready)
  );

`ifndef ASSERT_OFF
  // a read or clear transfer keeps the input closed in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready
      && ((s_axis_tuser == lpr_pkg::KIND_READ) || (s_axis_tuser == lpr_pkg::KIND_CLEAR)))
    |=> !s_axis_tready)
    else $error("input reopened right after a read or clear transfer");

  // the store is written only while no item can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.clr_step || cmd.wr_pixel || cmd.wr_head) |-> !s_axis_tready)
    else $error("store write while the input is open");

  // a flagged result carries a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("out of range result with nonzero data");

  // a result is loaded only when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_read || cmd.out_reject) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over a pending one");
`endif

endmodule
